// ----- hdl/ihla_pkg.sv -----
package ihla_pkg;

   // internal byte-address and size width, wide enough that no sum wraps
   localparam int AW       = 34;
   localparam int CHUNK_W  = 17;
   localparam int REQ_W    = 24;
   localparam int ADDR_W   = 20;
   localparam int STAT_W   = 2;
   localparam int TAG_W    = 32;
   localparam int NSTATE   = 38;

   localparam logic [CHUNK_W-1:0] CHUNK_RESET = 17'd4096;
   localparam logic [CHUNK_W-1:0] MIN_BLOCK   = 17'd16;
   localparam logic [TAG_W-1:0]   ALLOC_BIT   = 32'h1;

   localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_ZERO    = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NOSPACE = 2'd2;

   typedef enum logic [1:0] {
      ACT_INIT    = 2'd0,
      ACT_ALLOC   = 2'd1,
      ACT_RELEASE = 2'd2,
      ACT_RESIZE  = 2'd3
   } action_type;

   typedef enum logic [NSTATE-1:0] {
      S_IDLE    = 38'd1 << 0,
      S_INIT0   = 38'd1 << 1,
      S_INIT1   = 38'd1 << 2,
      S_INIT2   = 38'd1 << 3,
      S_INIT3   = 38'd1 << 4,
      S_ALC_CHK = 38'd1 << 5,
      S_FF_HDR  = 38'd1 << 6,
      S_FF_STRT = 38'd1 << 7,
      S_FF_TEST = 38'd1 << 8,
      S_FF_EVAL = 38'd1 << 9,
      S_GROW0   = 38'd1 << 10,
      S_GROW1   = 38'd1 << 11,
      S_GROW2   = 38'd1 << 12,
      S_GROW3   = 38'd1 << 13,
      S_MRG0    = 38'd1 << 14,
      S_MRG1    = 38'd1 << 15,
      S_MRG2    = 38'd1 << 16,
      S_MRG3    = 38'd1 << 17,
      S_MRG4    = 38'd1 << 18,
      S_MRG5    = 38'd1 << 19,
      S_MRG6P   = 38'd1 << 20,
      S_MRG6N   = 38'd1 << 21,
      S_MRG6B   = 38'd1 << 22,
      S_MRG7B   = 38'd1 << 23,
      S_MRG8B   = 38'd1 << 24,
      S_PL_RD   = 38'd1 << 25,
      S_PL_EV   = 38'd1 << 26,
      S_PS1     = 38'd1 << 27,
      S_PS2     = 38'd1 << 28,
      S_PS3     = 38'd1 << 29,
      S_PS4     = 38'd1 << 30,
      S_PN1     = 38'd1 << 31,
      S_PN2     = 38'd1 << 32,
      S_REL0    = 38'd1 << 33,
      S_REL1    = 38'd1 << 34,
      S_REL2    = 38'd1 << 35,
      S_REL3    = 38'd1 << 36,
      S_FIN     = 38'd1 << 37
   } state_type;

   typedef struct packed {
      logic       in_valid;
      action_type in_action;
      action_type act;
      logic       brk_zero;
      logic       req_zero;
      logic       grow_fail;
      logic       walk_end;
      logic       d_szero;
      logic       d_fit;
      logic       split;
      logic       rel_addr_ok;
      logic       rel_tag_ok;
      logic       p_alloc;
      logic       n_alloc;
      logic       slot_free;
   } dp_status_type;

endpackage

// ----- hdl/ihla_req_if.sv -----
interface ihla_req_if;
   import ihla_pkg::*;
   logic              valid;
   logic              ready;
   logic [1:0]        action;
   logic [REQ_W-1:0]  request_size;
   logic [ADDR_W-1:0] block_address;

   modport source (output valid, action, request_size, block_address, input ready);
   modport sink (input valid, action, request_size, block_address, output ready);
endinterface

// ----- hdl/ihla_rsp_if.sv -----
interface ihla_rsp_if;
   import ihla_pkg::*;
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] result_address;
   logic [STAT_W-1:0] status;

   modport source (output valid, result_address, status, input ready);
   modport sink (input valid, result_address, status, output ready);
endinterface

// ----- hdl/ihla_ctrl.sv -----
module ihla_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  ihla_pkg::dp_status_type stat,
   output ihla_pkg::state_type     cmd
);
   import ihla_pkg::*;

   state_type state_ff, state_in;
   logic      from_grow_ff, from_grow_in;
   state_type after_merge;

   assign cmd = state_ff;

   always_comb begin
      if (from_grow_ff) begin
         after_merge = (stat.act == ACT_INIT) ? S_FIN : S_PL_RD;
      end else begin
         after_merge = S_FIN;
      end
   end

   always_comb begin
      state_in     = state_ff;
      from_grow_in = from_grow_ff;
      case (state_ff)
         S_IDLE: begin
            if (stat.in_valid) begin
               case (stat.in_action)
                  ACT_INIT:    state_in = S_INIT0;
                  ACT_RELEASE: state_in = S_REL0;
                  default:     state_in = S_ALC_CHK;
               endcase
            end
         end
         S_INIT0:   state_in = S_INIT1;
         S_INIT1:   state_in = S_INIT2;
         S_INIT2:   state_in = S_INIT3;
         S_INIT3:   state_in = S_GROW0;
         S_ALC_CHK: state_in = (stat.brk_zero || stat.req_zero) ? S_FIN : S_FF_HDR;
         S_FF_HDR:  state_in = S_FF_STRT;
         S_FF_STRT: state_in = S_FF_TEST;
         S_FF_TEST: state_in = stat.walk_end ? S_GROW0 : S_FF_EVAL;
         S_FF_EVAL: begin
            if (stat.d_szero) begin
               state_in = S_GROW0;
            end else if (stat.d_fit) begin
               state_in = S_PL_RD;
            end else begin
               state_in = S_FF_TEST;
            end
         end
         S_GROW0: begin
            from_grow_in = 1'b1;
            state_in     = stat.grow_fail ? S_FIN : S_GROW1;
         end
         S_GROW1: state_in = S_GROW2;
         S_GROW2: state_in = S_GROW3;
         S_GROW3: state_in = S_MRG0;
         S_MRG0:  state_in = S_MRG1;
         S_MRG1:  state_in = S_MRG2;
         S_MRG2:  state_in = S_MRG3;
         S_MRG3:  state_in = S_MRG4;
         S_MRG4:  state_in = S_MRG5;
         S_MRG5: begin
            if (stat.p_alloc && stat.n_alloc) begin
               state_in = after_merge;
            end else if (stat.p_alloc) begin
               state_in = S_MRG6P;
            end else if (stat.n_alloc) begin
               state_in = S_MRG6N;
            end else begin
               state_in = S_MRG6B;
            end
         end
         S_MRG6P: state_in = after_merge;
         S_MRG6N: state_in = after_merge;
         S_MRG6B: state_in = S_MRG7B;
         S_MRG7B: state_in = S_MRG8B;
         S_MRG8B: state_in = after_merge;
         S_PL_RD: state_in = S_PL_EV;
         S_PL_EV: state_in = stat.split ? S_PS1 : S_PN1;
         S_PS1:   state_in = S_PS2;
         S_PS2:   state_in = S_PS3;
         S_PS3:   state_in = S_PS4;
         S_PS4:   state_in = (stat.act == ACT_RESIZE) ? S_REL0 : S_FIN;
         S_PN1:   state_in = S_PN2;
         S_PN2:   state_in = (stat.act == ACT_RESIZE) ? S_REL0 : S_FIN;
         S_REL0: begin
            from_grow_in = 1'b0;
            state_in     = stat.rel_addr_ok ? S_REL1 : S_FIN;
         end
         S_REL1: state_in = stat.rel_tag_ok ? S_REL2 : S_FIN;
         S_REL2: state_in = S_REL3;
         S_REL3: state_in = S_MRG0;
         S_FIN:  state_in = stat.slot_free ? S_IDLE : S_FIN;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         from_grow_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         from_grow_ff <= from_grow_in;
      end
   end

endmodule

// ----- hdl/ihla_dp.sv -----
module ihla_dp #(
   parameter int HEAP_WORDS = 262144
) (
   input  logic                               clock,
   input  logic                               reset,
   ihla_req_if.sink                           req,
   ihla_rsp_if.source                         rsp,
   input  logic                               csr_we,
   input  logic [ihla_pkg::CHUNK_W-1:0]       csr_wdata,
   input  ihla_pkg::state_type                cmd,
   output ihla_pkg::dp_status_type            stat
);
   import ihla_pkg::*;

   localparam int IDXW = $clog2(HEAP_WORDS);
   localparam logic [AW-1:0] HEAP_LIMIT = AW'(HEAP_WORDS);
   localparam logic [AW-1:0] HEAP_BYTES = AW'(HEAP_WORDS) << 2;

   logic [TAG_W-1:0] tag_mem [HEAP_WORDS];
   logic [TAG_W-1:0] rdata_ff;
   logic             rinr_ff;

   logic [AW-1:0] brk_ff, brk_in, bp_ff, bp_in, pbp_ff, pbp_in, s_ff, s_in;
   logic [AW-1:0] asize_ff, asize_in, psize_ff, psize_in, nsize_ff, nsize_in;
   logic [AW-1:0] t_ff, t_in;
   logic          palloc_ff, palloc_in, nalloc_ff, nalloc_in;
   action_type    act_ff, act_in;
   logic [REQ_W-1:0]   req_size_ff, req_size_in;
   logic [ADDR_W-1:0]  baddr_ff, baddr_in, res_addr_ff, res_addr_in;
   logic [STAT_W-1:0]  res_status_ff, res_status_in;
   logic [CHUNK_W-1:0] chunk_ff, chunk_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   logic [STAT_W-1:0]  rsp_status_ff, rsp_status_in;

   logic [AW-1:0]    maddr;
   logic             mwe;
   logic [TAG_W-1:0] mwdata;
   logic [IDXW-1:0]  midx;
   logic             minr;

   logic [TAG_W-1:0] dword;
   logic [AW-1:0]    dsize, chunk_eff, grow_bytes, grow_sz, baddr_ext, req_ext;
   logic             dalloc, slot_free, accept;

   // out-of-range tag words read as zero and drop writes
   assign dword  = rinr_ff ? rdata_ff : '0;
   assign dsize  = AW'({dword[TAG_W-1:3], 3'b000});
   assign dalloc = dword[0];

   assign chunk_eff  = AW'((chunk_ff < MIN_BLOCK) ? MIN_BLOCK : chunk_ff);
   assign grow_bytes = (act_ff == ACT_INIT) ? chunk_eff :
                       ((asize_ff > chunk_eff) ? asize_ff : chunk_eff);
   // round to an even word count
   assign grow_sz    = ((grow_bytes & ~AW'(3)) + AW'(4)) & ~AW'(7);
   assign baddr_ext  = AW'(baddr_ff);
   assign req_ext    = AW'(req_size_ff);

   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign accept    = (cmd == S_IDLE) && req.valid;

   assign req.ready          = (cmd == S_IDLE);
   assign rsp.valid          = rsp_valid_ff;
   assign rsp.result_address = rsp_addr_ff;
   assign rsp.status         = rsp_status_ff;

   always_comb begin
      stat.in_valid    = req.valid;
      stat.in_action   = action_type'(req.action);
      stat.act         = act_ff;
      stat.brk_zero    = (brk_ff == '0);
      stat.req_zero    = (req_size_ff == '0);
      stat.grow_fail   = grow_sz > (HEAP_BYTES - brk_ff);
      stat.walk_end    = !((bp_ff >= AW'(4)) && ((bp_ff - AW'(4)) < brk_ff));
      stat.d_szero     = (dsize == '0);
      stat.d_fit       = !dalloc && (asize_ff <= dsize);
      stat.split       = dsize >= (asize_ff + AW'(16));
      stat.rel_addr_ok = (brk_ff != '0) && (baddr_ff[2:0] == 3'b000) &&
                         (baddr_ext >= AW'(16)) && (baddr_ext < brk_ff);
      stat.rel_tag_ok  = dalloc && (dsize != '0) &&
                         ((baddr_ext + dsize - AW'(4)) <= brk_ff);
      stat.p_alloc     = palloc_ff;
      stat.n_alloc     = nalloc_ff;
      stat.slot_free   = slot_free;
   end

   always_comb begin
      brk_in        = brk_ff;
      bp_in         = bp_ff;
      pbp_in        = pbp_ff;
      s_in          = s_ff;
      asize_in      = asize_ff;
      psize_in      = psize_ff;
      nsize_in      = nsize_ff;
      t_in          = t_ff;
      palloc_in     = palloc_ff;
      nalloc_in     = nalloc_ff;
      act_in        = act_ff;
      req_size_in   = req_size_ff;
      baddr_in      = baddr_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      chunk_in      = csr_we ? csr_wdata : chunk_ff;
      rsp_valid_in  = (rsp_valid_ff && rsp.ready) ? 1'b0 : rsp_valid_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      maddr         = '0;
      mwe           = 1'b0;
      mwdata        = '0;
      case (cmd)
         S_IDLE: begin
            if (accept) begin
               act_in        = action_type'(req.action);
               req_size_in   = req.request_size;
               baddr_in      = req.block_address;
               res_addr_in   = '0;
               res_status_in = STAT_OK;
            end
         end
         S_INIT0: begin
            brk_in = '0;
            maddr  = AW'(0);
            mwe    = 1'b1;
            mwdata = '0;
         end
         S_INIT1: begin
            maddr  = AW'(4);
            mwe    = 1'b1;
            mwdata = TAG_W'(8) | ALLOC_BIT;
         end
         S_INIT2: begin
            maddr  = AW'(8);
            mwe    = 1'b1;
            mwdata = TAG_W'(8) | ALLOC_BIT;
         end
         S_INIT3: begin
            brk_in = AW'(16);
            maddr  = AW'(12);
            mwe    = 1'b1;
            mwdata = ALLOC_BIT;
         end
         S_ALC_CHK: begin
            asize_in = (req_ext <= AW'(8)) ? AW'(MIN_BLOCK) :
                       ((req_ext + AW'(15)) & ~AW'(7));
            if (brk_ff == '0) begin
               res_status_in = STAT_NOSPACE;
            end else if (req_size_ff == '0) begin
               res_status_in = STAT_ZERO;
            end
         end
         S_FF_HDR:  maddr = AW'(4);
         S_FF_STRT: bp_in = AW'(8) + dsize;
         S_FF_TEST: maddr = bp_ff - AW'(4);
         S_FF_EVAL: begin
            s_in = dsize;
            if (!stat.d_fit && dsize != '0) begin
               bp_in = bp_ff + dsize;
            end
         end
         S_GROW0: begin
            if (stat.grow_fail) begin
               res_status_in = STAT_NOSPACE;
               res_addr_in   = '0;
            end else begin
               bp_in  = brk_ff;
               brk_in = brk_ff + grow_sz;
               s_in   = grow_sz;
            end
         end
         S_GROW1: begin
            maddr  = bp_ff - AW'(4);
            mwe    = 1'b1;
            mwdata = s_ff[TAG_W-1:0];
         end
         S_GROW2: begin
            maddr  = bp_ff + s_ff - AW'(8);
            mwe    = 1'b1;
            mwdata = s_ff[TAG_W-1:0];
         end
         S_GROW3: begin
            // new epilogue
            maddr  = bp_ff + s_ff - AW'(4);
            mwe    = 1'b1;
            mwdata = ALLOC_BIT;
         end
         S_MRG0: maddr = bp_ff - AW'(8);
         S_MRG1: pbp_in = bp_ff - dsize;
         S_MRG2: maddr = pbp_ff - AW'(4);
         S_MRG3: begin
            palloc_in = dalloc;
            psize_in  = dsize;
            maddr     = bp_ff + s_ff - AW'(4);
         end
         S_MRG4: begin
            nalloc_in = dalloc;
            nsize_in  = dsize;
            t_in      = bp_ff + s_ff + dsize - AW'(8);
         end
         S_MRG5: begin
            if (palloc_ff && !nalloc_ff) begin
               s_in   = s_ff + nsize_ff;
               maddr  = bp_ff - AW'(4);
               mwe    = 1'b1;
               mwdata = TAG_W'(s_ff + nsize_ff);
            end else if (!palloc_ff && nalloc_ff) begin
               s_in   = s_ff + psize_ff;
               maddr  = bp_ff + s_ff - AW'(8);
               mwe    = 1'b1;
               mwdata = TAG_W'(s_ff + psize_ff);
            end else if (!palloc_ff && !nalloc_ff) begin
               maddr = t_ff;
            end
         end
         S_MRG6P: begin
            maddr  = bp_ff + s_ff - AW'(8);
            mwe    = 1'b1;
            mwdata = s_ff[TAG_W-1:0];
         end
         S_MRG6N: begin
            bp_in  = pbp_ff;
            maddr  = pbp_ff - AW'(4);
            mwe    = 1'b1;
            mwdata = s_ff[TAG_W-1:0];
         end
         S_MRG6B: s_in = s_ff + psize_ff + dsize;
         S_MRG7B: begin
            maddr  = pbp_ff - AW'(4);
            mwe    = 1'b1;
            mwdata = s_ff[TAG_W-1:0];
         end
         S_MRG8B: begin
            bp_in  = pbp_ff;
            maddr  = t_ff;
            mwe    = 1'b1;
            mwdata = s_ff[TAG_W-1:0];
         end
         S_PL_RD: maddr = bp_ff - AW'(4);
         S_PL_EV: begin
            s_in        = dsize;
            res_addr_in = bp_ff[ADDR_W-1:0];
         end
         S_PS1: begin
            maddr  = bp_ff - AW'(4);
            mwe    = 1'b1;
            mwdata = asize_ff[TAG_W-1:0] | ALLOC_BIT;
         end
         S_PS2: begin
            maddr  = bp_ff + asize_ff - AW'(8);
            mwe    = 1'b1;
            mwdata = asize_ff[TAG_W-1:0] | ALLOC_BIT;
         end
         S_PS3: begin
            maddr  = bp_ff + asize_ff - AW'(4);
            mwe    = 1'b1;
            mwdata = TAG_W'(s_ff - asize_ff);
         end
         S_PS4: begin
            maddr  = bp_ff + s_ff - AW'(8);
            mwe    = 1'b1;
            mwdata = TAG_W'(s_ff - asize_ff);
         end
         S_PN1: begin
            maddr  = bp_ff - AW'(4);
            mwe    = 1'b1;
            mwdata = s_ff[TAG_W-1:0] | ALLOC_BIT;
         end
         S_PN2: begin
            maddr  = bp_ff + s_ff - AW'(8);
            mwe    = 1'b1;
            mwdata = s_ff[TAG_W-1:0] | ALLOC_BIT;
         end
         S_REL0: maddr = baddr_ext - AW'(4);
         S_REL1: begin
            bp_in = baddr_ext;
            s_in  = dsize;
         end
         S_REL2: begin
            maddr  = bp_ff - AW'(4);
            mwe    = 1'b1;
            mwdata = s_ff[TAG_W-1:0];
         end
         S_REL3: begin
            maddr  = bp_ff + s_ff - AW'(8);
            mwe    = 1'b1;
            mwdata = s_ff[TAG_W-1:0];
         end
         S_FIN: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = res_status_ff;
            end
         end
         default: begin
            maddr = '0;
         end
      endcase
   end

   assign midx = maddr[IDXW+1:2];
   assign minr = (maddr >> 2) < HEAP_LIMIT;

   always_ff @(posedge clock) begin
      if (mwe && minr) begin
         tag_mem[midx] <= mwdata;
      end
      rdata_ff <= tag_mem[midx];
      rinr_ff  <= minr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         brk_ff       <= '0;
         chunk_ff     <= CHUNK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         brk_ff       <= brk_in;
         chunk_ff     <= chunk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bp_ff         <= bp_in;
      pbp_ff        <= pbp_in;
      s_ff          <= s_in;
      asize_ff      <= asize_in;
      psize_ff      <= psize_in;
      nsize_ff      <= nsize_in;
      t_ff          <= t_in;
      palloc_ff     <= palloc_in;
      nalloc_ff     <= nalloc_in;
      act_ff        <= act_in;
      req_size_ff   <= req_size_in;
      baddr_ff      <= baddr_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

// ----- hdl/implicit_list_heap_allocator.sv -----
// Boundary-tag heap allocator, first-fit over an implicit block list.
// req_bus carries one beat per command: action (init, allocate, release,
// resize), request_size and block_address. rsp_bus returns one beat per
// command: result_address and status. csr_we/csr_wdata set the minimum heap
// growth in bytes; write it only while the block is idle.
// Commands run one at a time through a state machine that issues one tag
// memory access per cycle on a single-port memory with registered read.
// Init writes the prologue and epilogue, then grows the heap; allocate walks
// the block list first-fit, grows the heap when no block fits, and splits the
// chosen block when it is large enough; release checks the address and then
// the tag, frees the block and coalesces it; resize is an allocate followed
// by a release of the old block; zero size or no heap ends at the size check.
// The walk length, set by heap fragmentation, dominates the command time.
// The next command is taken from the cycle after the result is loaded.
// Reset clears the heap break and sets growth to 4096 bytes; the tag memory
// is not cleared, so init must be the first command.
// The result sits in an output register; a new command is taken while it
// waits, but a finished command holds its state until the result slot frees.
module implicit_list_heap_allocator #(
   parameter int HEAP_WORDS = 262144
) (
   input  logic                         clock,
   input  logic                         reset,
   ihla_req_if.sink                     req_bus,
   ihla_rsp_if.source                   rsp_bus,
   input  logic                         csr_we,
   input  logic [ihla_pkg::CHUNK_W-1:0] csr_wdata
);
   import ihla_pkg::*;

   state_type     cmd;
   dp_status_type stat;

   ihla_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   ihla_dp #(
      .HEAP_WORDS (HEAP_WORDS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;
   import ihla_pkg::*;

   localparam int HW          = 262144;
   localparam int CYCLE_LIMIT = 6000000;

   typedef struct {
      logic [ADDR_W-1:0] addr;
      logic [STAT_W-1:0] status;
   } heap_reply_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CHUNK_W-1:0] csr_wdata;

   ihla_req_if req_bus ();
   ihla_rsp_if rsp_bus ();

   implicit_list_heap_allocator u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // heap shadow
   bit [31:0] shadow_tags[HW];
   bit        shadow_seen[HW];
   longint unsigned shadow_break;
   longint unsigned shadow_chunk;

   heap_reply_type pending_replies[$];
   int unsigned live_blocks[$];
   int errors;
   longint cycles;
   bit req_no_gaps;
   bit rsp_no_stalls;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic bit [31:0] tag_rd(longint unsigned a);
      longint unsigned i = a >> 2;
      return (i < HW) ? shadow_tags[i] : 32'h0;
   endfunction

   function automatic void tag_wr(longint unsigned a, longint unsigned v);
      longint unsigned i = a >> 2;
      if (i < HW) begin
         shadow_tags[i] = v[31:0];
         shadow_seen[i] = 1'b1;
      end
   endfunction

   function automatic longint unsigned blk_size(longint unsigned a);
      return 64'(tag_rd(a) & 32'hFFFF_FFF8);
   endfunction

   function automatic bit blk_used(longint unsigned a);
      return (tag_rd(a) & ALLOC_BIT) != 32'h0;
   endfunction

   function automatic longint unsigned coalesce(longint unsigned bp);
      longint unsigned pb, nb, nfoot, s;
      bit p, n;
      pb    = bp - blk_size(bp - 8);
      nb    = bp + blk_size(bp - 4);
      nfoot = nb + blk_size(nb - 4) - 8;
      p     = blk_used(pb - 4);
      n     = blk_used(nb - 4);
      s     = blk_size(bp - 4);
      if (p && n) return bp;
      if (p) begin
         s += blk_size(nb - 4);
         tag_wr(bp - 4, s);
         tag_wr(nfoot, s);
         return bp;
      end
      if (n) begin
         s += blk_size(pb - 4);
         tag_wr(bp + blk_size(bp - 4) - 8, s);
         tag_wr(pb - 4, s);
         return pb;
      end
      s += blk_size(pb - 4) + blk_size(nfoot);
      tag_wr(pb - 4, s);
      tag_wr(nfoot, s);
      return pb;
   endfunction

   function automatic bit heap_grow(longint unsigned bytes, output longint unsigned bp);
      longint unsigned words, sz;
      words = bytes >> 2;
      if (words & 1) words++;
      sz = words * 4;
      bp = 0;
      if (sz > longint'(HW) * 4 - shadow_break) return 1'b0;
      bp = shadow_break;
      shadow_break += sz;
      tag_wr(bp - 4, sz);
      tag_wr(bp + sz - 8, sz);
      tag_wr(bp + sz - 4, ALLOC_BIT);
      bp = coalesce(bp);
      return 1'b1;
   endfunction

   function automatic bit first_fit(longint unsigned asize, output longint unsigned found);
      longint unsigned bp, s;
      bp = 8 + blk_size(4);
      found = 0;
      while (bp >= 4 && bp - 4 < shadow_break) begin
         s = blk_size(bp - 4);
         if (s == 0) break;
         if (!blk_used(bp - 4) && asize <= s) begin
            found = bp;
            return 1'b1;
         end
         bp += s;
      end
      return 1'b0;
   endfunction

   function automatic void place_block(longint unsigned bp, longint unsigned asize);
      longint unsigned orig, rem, nb;
      orig = blk_size(bp - 4);
      rem  = (orig >= asize) ? orig - asize : 0;
      if (rem >= MIN_BLOCK) begin
         tag_wr(bp - 4, asize | ALLOC_BIT);
         tag_wr(bp + asize - 8, asize | ALLOC_BIT);
         nb = bp + asize;
         tag_wr(nb - 4, rem);
         tag_wr(nb + rem - 8, rem);
      end else begin
         tag_wr(bp - 4, orig | ALLOC_BIT);
         tag_wr(bp + orig - 8, orig | ALLOC_BIT);
      end
   endfunction

   function automatic longint unsigned grow_amount();
      return (shadow_chunk < MIN_BLOCK) ? MIN_BLOCK : shadow_chunk;
   endfunction

   function automatic logic [STAT_W-1:0] heap_alloc(longint unsigned rsize,
                                                    output longint unsigned addr);
      longint unsigned asize, bp, ext;
      addr = 0;
      if (shadow_break == 0) return STAT_NOSPACE;
      if (rsize == 0) return STAT_ZERO;
      asize = (rsize <= 8) ? MIN_BLOCK : 8 * ((rsize + 15) / 8);
      if (!first_fit(asize, bp)) begin
         ext = (asize > grow_amount()) ? asize : grow_amount();
         if (!heap_grow(ext, bp)) return STAT_NOSPACE;
      end
      place_block(bp, asize);
      addr = bp;
      return STAT_OK;
   endfunction

   function automatic void heap_free(longint unsigned a);
      longint unsigned s, dummy;
      if (shadow_break == 0 || (a & 7) != 0 || a < 16) return;
      if (a >= shadow_break || !blk_used(a - 4)) return;
      s = blk_size(a - 4);
      if (s == 0 || a + s - 4 > shadow_break) return;
      tag_wr(a - 4, s);
      tag_wr(a + s - 8, s);
      dummy = coalesce(a);
   endfunction

   function automatic heap_reply_type predict_reply(action_type act, longint unsigned rsize,
                                                    longint unsigned baddr);
      heap_reply_type r;
      longint unsigned addr, bp;
      addr     = 0;
      r.status = STAT_OK;
      case (act)
         ACT_INIT: begin
            foreach (shadow_seen[i]) shadow_seen[i] = 1'b0;
            shadow_break = 0;
            tag_wr(0, 0);
            tag_wr(4, 8 | ALLOC_BIT);
            tag_wr(8, 8 | ALLOC_BIT);
            tag_wr(12, ALLOC_BIT);
            shadow_break = 16;
            if (!heap_grow(grow_amount(), bp)) r.status = STAT_NOSPACE;
         end
         ACT_ALLOC: r.status = heap_alloc(rsize, addr);
         ACT_RELEASE: heap_free(baddr);
         default: begin
            r.status = heap_alloc(rsize, addr);
            if (r.status == STAT_OK) heap_free(baddr);
         end
      endcase
      r.addr = addr[ADDR_W-1:0];
      return r;
   endfunction

   // a release that stops at its first checks, so it never reads an unwritten word
   function automatic bit harmless_release(longint unsigned a);
      longint unsigned i;
      if (shadow_break == 0 || (a & 7) != 0 || a < 16 || a >= shadow_break) return 1'b1;
      i = (a - 4) >> 2;
      return shadow_seen[i] && !shadow_tags[i][0];
   endfunction

   function automatic int unsigned idle_draw(bit no_idle);
      return no_idle ? 0 : $urandom_range(0, 11);
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   task automatic send_cmd(action_type act, int unsigned rsize, int unsigned baddr,
                           output int unsigned new_addr);
      heap_reply_type r;
      int unsigned gap;
      r = predict_reply(act, rsize, baddr);
      pending_replies.push_back(r);
      new_addr = 32'(r.addr);
      if (act == ACT_INIT) live_blocks.delete();
      if (act == ACT_RELEASE || (act == ACT_RESIZE && r.status == STAT_OK)) begin
         foreach (live_blocks[i]) begin
            if (live_blocks[i] == baddr) begin
               live_blocks.delete(i);
               break;
            end
         end
      end
      if ((act == ACT_ALLOC || act == ACT_RESIZE) && r.status == STAT_OK)
         live_blocks.push_back(32'(r.addr));
      gap = idle_draw(req_no_gaps);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.action        <= act;
      req_bus.request_size  <= rsize[REQ_W-1:0];
      req_bus.block_address <= baddr[ADDR_W-1:0];
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_chunk(int unsigned v);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= v[CHUNK_W-1:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      shadow_chunk = v & 32'h1FFFF;
   endtask

   function automatic int unsigned pick_size();
      int unsigned r = $urandom_range(0, 99);
      if (r < 3) return 0;
      if (r < 6) return $urandom & 32'hFF_FFFF;
      if (r < 10) return $urandom_range(1000, 70000);
      if (r < 20) return $urandom_range(1, 16);
      return $urandom_range(1, 300);
   endfunction

   function automatic int unsigned pick_bad_addr();
      int unsigned a;
      repeat (8) begin
         case ($urandom_range(0, 3))
            0: a = $urandom & 32'hF_FFFF;
            1: a = $urandom_range(0, 15);
            2: a = $urandom_range(shadow_break, 32'hF_FFFF);
            default: a = $urandom_range(16, shadow_break + 16) & ~32'h7;
         endcase
         if (a <= 32'hF_FFFF && harmless_release(a)) return a;
      end
      return ($urandom & 32'hF_FFFF) | 32'h1;
   endfunction

   function automatic int unsigned pick_target();
      if (live_blocks.size() != 0 && $urandom_range(0, 99) < 85)
         return live_blocks[$urandom_range(0, live_blocks.size() - 1)];
      return pick_bad_addr();
   endfunction

   task automatic run_traffic(int n);
      int unsigned r, addr;
      for (int k = 0; k < n; k++) begin
         if (k % 60 == 0) begin
            req_no_gaps   = ($urandom_range(0, 3) == 0);
            rsp_no_stalls = ($urandom_range(0, 3) == 0);
         end
         r = $urandom_range(0, 99);
         // drain when many blocks are live so the walk stays short
         if (live_blocks.size() > 150 && r < 50) r = 60;
         if (r < 2)
            send_cmd(ACT_INIT, $urandom & 32'hFF_FFFF, $urandom & 32'hF_FFFF, addr);
         else if (r < 50)
            send_cmd(ACT_ALLOC, pick_size(), pick_bad_addr(), addr);
         else if (r < 86)
            send_cmd(ACT_RELEASE, $urandom & 32'hFF_FFFF, pick_target(), addr);
         else
            send_cmd(ACT_RESIZE, pick_size(), pick_target(), addr);
      end
   endtask

   task automatic test_before_init();
      int unsigned addr;
      send_cmd(ACT_ALLOC, 8, 0, addr);
      send_cmd(ACT_RELEASE, 0, 16, addr);
      send_cmd(ACT_RESIZE, 24, 16, addr);
   endtask

   task automatic test_directed();
      int unsigned a, b, c, d, e, addr;
      send_cmd(ACT_INIT, 0, 0, addr);
      send_cmd(ACT_ALLOC, 0, 0, addr);
      send_cmd(ACT_ALLOC, 1, 0, a);
      send_cmd(ACT_ALLOC, 8, 0, b);
      send_cmd(ACT_ALLOC, 9, 0, c);
      send_cmd(ACT_ALLOC, 100, 0, d);
      send_cmd(ACT_ALLOC, 40, 0, e);
      send_cmd(ACT_ALLOC, 24'hFF_FFFF, 0, addr);
      send_cmd(ACT_RESIZE, 0, a, addr);
      send_cmd(ACT_RESIZE, 24'hFF_FFFF, a, addr);
      send_cmd(ACT_RELEASE, 0, 20'hF_FFFF, addr);
      send_cmd(ACT_RELEASE, 0, 0, addr);
      send_cmd(ACT_RELEASE, 0, 8, addr);
      send_cmd(ACT_RELEASE, 0, 20'hF_FFF8, addr);
      // neither neighbor free, then prev free, next free, next free again, both free
      send_cmd(ACT_RELEASE, 0, b, addr);
      send_cmd(ACT_RELEASE, 0, c, addr);
      send_cmd(ACT_RELEASE, 0, a, addr);
      send_cmd(ACT_RELEASE, 0, e, addr);
      send_cmd(ACT_RELEASE, 0, d, addr);
      send_cmd(ACT_RELEASE, 0, d, addr);
      send_cmd(ACT_ALLOC, 10000, 0, a);
      send_cmd(ACT_RESIZE, 17, a, addr);
      send_cmd(ACT_RELEASE, 0, addr, addr);
   endtask

   task automatic test_heap_full();
      int unsigned addr;
      write_chunk(65536);
      send_cmd(ACT_INIT, 0, 0, addr);
      repeat (7) send_cmd(ACT_ALLOC, 200000, 0, addr);
      send_cmd(ACT_ALLOC, 24, 0, addr);
      send_cmd(ACT_RESIZE, 300000, live_blocks[0], addr);
   endtask

   task automatic test_chunk_settings();
      int unsigned settings[$];
      int unsigned addr;
      settings = '{16, 0, 131071, 24, ($urandom_range(2, 8191) * 8), 65536, 4096};
      foreach (settings[i]) begin
         write_chunk(settings[i]);
         send_cmd(ACT_INIT, 0, 0, addr);
         run_traffic(280);
      end
   endtask

   // result side stall pattern
   initial begin
      int unsigned stall;
      rsp_bus.ready <= 1'b0;
      forever begin
         stall = idle_draw(rsp_no_stalls);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
      end
   end

   always @(posedge clock) begin
      heap_reply_type want;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end else if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_replies.size() == 0) begin
            report_mismatch("unexpected beat, address", rsp_bus.result_address, -1);
         end else begin
            want = pending_replies.pop_front();
            if (rsp_bus.result_address !== want.addr)
               report_mismatch("result_address", rsp_bus.result_address, want.addr);
            if (rsp_bus.status !== want.status)
               report_mismatch("status", rsp_bus.status, want.status);
         end
      end
   end

   initial begin
      errors        = 0;
      cycles        = 0;
      shadow_break  = 0;
      shadow_chunk  = CHUNK_RESET;
      req_no_gaps   = 1'b0;
      rsp_no_stalls = 1'b0;
      reset                 <= 1'b1;
      csr_we                <= 1'b0;
      csr_wdata             <= '0;
      req_bus.valid         <= 1'b0;
      req_bus.action        <= ACT_INIT;
      req_bus.request_size  <= '0;
      req_bus.block_address <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_before_init();
      test_directed();
      test_heap_full();
      test_chunk_settings();
      wait_idle();
      if (errors == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule
